// ===== sv/mbrs_pkg.sv =====
//==============================================================================
// mbrs_pkg
// Shared types and constants for the motion burst read sequencer.
//==============================================================================
`default_nettype none

package mbrs_pkg;

   // Burst geometry
   localparam int BURST_BYTES = 12;
   localparam int IDX_W       = $clog2(BURST_BYTES + 1);
   // Only bytes 0..6 of a burst are buffered for the packed result (byte 1 is unused)
   localparam int PACK_BYTES  = 7;
   localparam int PACK_IDX_W  = $clog2(PACK_BYTES);

   // Field widths
   localparam int MODE_W     = 3;
   localparam int BYTE_W     = 8;
   localparam int DELTA_W    = 16;
   localparam int PHASE_W    = 3;
   localparam int CMD_W      = 7;
   localparam int GAP_W      = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   // Register reset values
   localparam logic [GAP_W-1:0] GAP_TICKS_RST = GAP_W'(1);

   // Request event codes
   typedef enum logic [MODE_W-1:0] {
      MODE_START     = 3'd0,
      MODE_XFER_DONE = 3'd1,
      MODE_RX_BYTE   = 3'd2,
      MODE_TICK      = 3'd3,
      MODE_ACK       = 3'd4
   } mode_type;

   // Sequencer phases
   typedef enum logic [PHASE_W-1:0] {
      PH_IDLE  = 3'd0,
      PH_CMD   = 3'd1,
      PH_GAP   = 3'd2,
      PH_READ  = 3'd3,
      PH_DONE  = 3'd4,
      PH_ERROR = 3'd5
   } phase_type;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BURST_CMD = 2'd0,
      CSR_GAP_TICKS = 2'd1
   } csr_index_type;

   // One request
   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              spi_busy;
      logic              launch_ok;
      logic              transfer_error;
      logic [BYTE_W-1:0] rx_byte;
   } req_type;

   // One result
   typedef struct packed {
      logic [PHASE_W-1:0]        state_code;
      logic                      busy_res;
      logic                      select_active;
      logic                      start_accepted;
      logic                      done_ack;
      logic                      request_command;
      logic                      request_read;
      logic [BYTE_W-1:0]         motion_status;
      logic signed [DELTA_W-1:0] delta_x;
      logic signed [DELTA_W-1:0] delta_y;
      logic [BYTE_W-1:0]         surface_quality;
   } rsp_type;

   // Busy phases: chip select is low exactly in these
   function automatic logic phase_busy(input phase_type ph);
      return (ph == PH_CMD) || (ph == PH_GAP) || (ph == PH_READ);
   endfunction

endpackage

`default_nettype wire

// ===== sv/mbrs_req_if.sv =====
//==============================================================================
// mbrs_req_if
// Request channel: one sequencer event per accepted request.
//==============================================================================
`default_nettype none

interface mbrs_req_if
   import mbrs_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [MODE_W-1:0]   mode;
   logic                spi_busy;
   logic                launch_ok;
   logic                transfer_error;
   logic [BYTE_W-1:0]   rx_byte;

   modport source (output valid, mode, spi_busy, launch_ok, transfer_error, rx_byte,
                   input ready);
   modport sink   (input valid, mode, spi_busy, launch_ok, transfer_error, rx_byte,
                   output ready);
endinterface

`default_nettype wire

// ===== sv/mbrs_rsp_if.sv =====
//==============================================================================
// mbrs_rsp_if
// Response channel: sequencer status and packed motion data.
//==============================================================================
`default_nettype none

interface mbrs_rsp_if
   import mbrs_pkg::*;
   ();
   logic                      valid;
   logic                      ready;
   logic [PHASE_W-1:0]        state_code;
   logic                      busy_res;
   logic                      select_active;
   logic                      start_accepted;
   logic                      done_ack;
   logic                      request_command;
   logic                      request_read;
   logic [BYTE_W-1:0]         motion_status;
   logic signed [DELTA_W-1:0] delta_x;
   logic signed [DELTA_W-1:0] delta_y;
   logic [BYTE_W-1:0]         surface_quality;

   modport source (output valid, state_code, busy_res, select_active, start_accepted,
                          done_ack, request_command, request_read, motion_status,
                          delta_x, delta_y, surface_quality,
                   input  ready);
   modport sink   (input  valid, state_code, busy_res, select_active, start_accepted,
                          done_ack, request_command, request_read, motion_status,
                          delta_x, delta_y, surface_quality,
                   output ready);
endinterface

`default_nettype wire

// ===== sv/mbrs_csr_if.sv =====
//==============================================================================
// mbrs_csr_if
// Configuration write channel: register index and write data.
//==============================================================================
`default_nettype none

interface mbrs_csr_if
   import mbrs_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

`default_nettype wire

// ===== sv/mbrs_csr.sv =====
//==============================================================================
// mbrs_csr
// Configuration registers. The burst command address is never reflected in a
// response, so only gap_ticks is held here.
//==============================================================================
`default_nettype none

module mbrs_csr
   import mbrs_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  wr_en,
   input  wire logic [CSR_IDX_W-1:0]  wr_index,
   input  wire logic [CSR_DATA_W-1:0] wr_data,
   output logic [GAP_W-1:0]           gap_ticks
);

   logic [GAP_W-1:0] gap_ticks_ff;
   logic [GAP_W-1:0] gap_ticks_in;

   // Register decode
   always_comb begin
      gap_ticks_in = gap_ticks_ff;
      if (wr_en) begin
         unique case (csr_index_type'(wr_index))
            CSR_GAP_TICKS: gap_ticks_in = wr_data[GAP_W-1:0];
            CSR_BURST_CMD: gap_ticks_in = gap_ticks_ff;
            default:       gap_ticks_in = gap_ticks_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ticks_ff <= GAP_TICKS_RST;
      end else begin
         gap_ticks_ff <= gap_ticks_in;
      end
   end

   assign gap_ticks = gap_ticks_ff;

endmodule

`default_nettype wire

// ===== sv/mbrs_ctrl.sv =====
//==============================================================================
// mbrs_ctrl
// Sequencer phase, gap counter, burst byte capture and packed motion hold.
// Computes the response for the request accepted this cycle.
//==============================================================================
`default_nettype none

module mbrs_ctrl
   import mbrs_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire req_type          req,
   input  wire logic [GAP_W-1:0] gap_ticks,
   output rsp_type               rsp
);

   phase_type                 phase_ff, phase_in;
   logic [GAP_W-1:0]          gap_count_ff;
   logic [IDX_W-1:0]          byte_idx_ff;
   logic [BYTE_W-1:0]         buf_ff [PACK_BYTES];
   logic [BYTE_W-1:0]         motion_ff, motion_in;
   logic signed [DELTA_W-1:0] dx_ff, dx_in;
   logic signed [DELTA_W-1:0] dy_ff, dy_in;
   logic [BYTE_W-1:0]         quality_ff, quality_in;

   mode_type         mode;
   logic             is_busy;
   logic             start_ok;
   logic             ev_start, ev_done, ev_rx, ev_tick, ev_ack;
   logic [GAP_W-1:0] gap_next;
   logic             read_launch;
   logic             cmd_ok;
   logic             read_ok;
   logic             rx_store;

   // Event decode
   assign mode     = mode_type'(req.mode);
   assign is_busy  = phase_busy(phase_ff);
   assign start_ok = !is_busy && !req.spi_busy;

   always_comb begin
      ev_start = 1'b0;
      ev_done  = 1'b0;
      ev_rx    = 1'b0;
      ev_tick  = 1'b0;
      ev_ack   = 1'b0;
      unique case (mode)
         MODE_START:     ev_start = accept;
         MODE_XFER_DONE: ev_done  = accept;
         MODE_RX_BYTE:   ev_rx    = accept;
         MODE_TICK:      ev_tick  = accept;
         MODE_ACK:       ev_ack   = accept;
         default:        ev_start = 1'b0;
      endcase
   end

   // Gap counter saturates at gap_ticks; read launches once reached and SPI free
   assign gap_next    = (gap_count_ff < gap_ticks) ? gap_count_ff + GAP_W'(1) : gap_count_ff;
   assign read_launch = ev_tick && (phase_ff == PH_GAP) && (gap_next >= gap_ticks)
                        && !req.spi_busy;
   assign cmd_ok      = ev_done && (phase_ff == PH_CMD) && !req.transfer_error;
   assign read_ok     = ev_done && (phase_ff == PH_READ) && !req.transfer_error;
   assign rx_store    = ev_rx && (phase_ff == PH_READ) && (byte_idx_ff < IDX_W'(BURST_BYTES));

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (ev_start && start_ok) begin
         phase_in = req.launch_ok ? PH_CMD : PH_ERROR;
      end else if (ev_done && phase_ff == PH_CMD) begin
         phase_in = req.transfer_error ? PH_ERROR : PH_GAP;
      end else if (ev_done && phase_ff == PH_READ) begin
         phase_in = req.transfer_error ? PH_ERROR : PH_DONE;
      end else if (read_launch) begin
         phase_in = req.launch_ok ? PH_READ : PH_ERROR;
      end else if (ev_ack && phase_ff == PH_DONE) begin
         phase_in = PH_IDLE;
      end
   end

   // Packed motion values, little-endian deltas
   always_comb begin
      motion_in  = motion_ff;
      dx_in      = dx_ff;
      dy_in      = dy_ff;
      quality_in = quality_ff;
      if (read_ok) begin
         motion_in  = buf_ff[0];
         dx_in      = {buf_ff[3], buf_ff[2]};
         dy_in      = {buf_ff[5], buf_ff[4]};
         quality_in = buf_ff[6];
      end
   end

   // Response fields; done phase stands for a completed, unacknowledged read
   always_comb begin
      rsp.state_code      = phase_in;
      rsp.busy_res        = phase_busy(phase_in);
      rsp.select_active   = phase_busy(phase_in);
      rsp.start_accepted  = ev_start && start_ok && req.launch_ok;
      rsp.done_ack        = ev_ack && (phase_ff == PH_DONE);
      rsp.request_command = ev_start && start_ok;
      rsp.request_read    = read_launch;
      rsp.motion_status   = motion_in;
      rsp.delta_x         = dx_in;
      rsp.delta_y         = dy_in;
      rsp.surface_quality = quality_in;
   end

   // Phase and held values
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         motion_ff  <= '0;
         dx_ff      <= '0;
         dy_ff      <= '0;
         quality_ff <= '0;
      end else begin
         phase_ff   <= phase_in;
         motion_ff  <= motion_in;
         dx_ff      <= dx_in;
         dy_ff      <= dy_in;
         quality_ff <= quality_in;
      end
   end

   // Gap counter
   always_ff @(posedge clock) begin
      if (reset) begin
         gap_count_ff <= '0;
      end else if (cmd_ok) begin
         gap_count_ff <= '0;
      end else if (ev_tick && phase_ff == PH_GAP) begin
         gap_count_ff <= gap_next;
      end
   end

   // Burst capture: cleared at read launch, bytes past the burst dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_idx_ff <= '0;
         for (int i = 0; i < PACK_BYTES; i++) begin
            buf_ff[i] <= '0;
         end
      end else if (read_launch) begin
         byte_idx_ff <= '0;
         for (int i = 0; i < PACK_BYTES; i++) begin
            buf_ff[i] <= '0;
         end
      end else if (rx_store) begin
         byte_idx_ff <= byte_idx_ff + IDX_W'(1);
         if (byte_idx_ff < IDX_W'(PACK_BYTES)) begin
            buf_ff[byte_idx_ff[PACK_IDX_W-1:0]] <= req.rx_byte;
         end
      end
   end

endmodule

`default_nettype wire

// ===== sv/mbrs_rsp_reg.sv =====
//==============================================================================
// mbrs_rsp_reg
// Response output register. Loads while empty or while being drained, so a
// new request is taken every cycle the downstream side keeps up.
//==============================================================================
`default_nettype none

module mbrs_rsp_reg
   import mbrs_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    load,
   input  wire rsp_type data_in,
   input  wire logic    out_ready,
   output logic         out_valid,
   output rsp_type      data_out,
   output logic         can_load
);

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign can_load = !valid_ff || out_ready;
   assign valid_in = load || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign data_out  = data_ff;

endmodule

`default_nettype wire

// ===== sv/motion_burst_read_sequencer_unit.sv =====
// Latency: a request accepted at a clock edge has its response valid from the next cycle.
// Throughput: one request per cycle while the response side keeps up; the response register is the only stage and
//   takes a new request whenever it is empty or is being drained.
// Reset (synchronous, active high): phase idle, counters, burst buffer and held
//   motion values cleared, gap_ticks back to 1, no response pending.
//==============================================================================
// motion_burst_read_sequencer_unit
// Non-blocking motion burst read sequencer for an optical-flow sensor on a
// shared SPI engine.
//==============================================================================
`default_nettype none

module motion_burst_read_sequencer_unit
   import mbrs_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   mbrs_req_if.sink    req_if,
   mbrs_rsp_if.source  rsp_if,
   mbrs_csr_if.sink    csr_if
);

   logic             req_accept;
   logic             can_load;
   logic [GAP_W-1:0] gap_ticks;
   req_type          req;
   rsp_type          rsp_next;
   rsp_type          rsp_out;

   // Configuration port is always ready
   assign csr_if.ready = 1'b1;

   mbrs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (csr_if.valid),
      .wr_index  (csr_if.index),
      .wr_data   (csr_if.wdata),
      .gap_ticks (gap_ticks)
   );

   // Request handshake
   assign req_if.ready = can_load;
   assign req_accept   = req_if.valid && can_load;

   assign req.mode           = req_if.mode;
   assign req.spi_busy       = req_if.spi_busy;
   assign req.launch_ok      = req_if.launch_ok;
   assign req.transfer_error = req_if.transfer_error;
   assign req.rx_byte        = req_if.rx_byte;

   mbrs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .req       (req),
      .gap_ticks (gap_ticks),
      .rsp       (rsp_next)
   );

   mbrs_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (req_accept),
      .data_in   (rsp_next),
      .out_ready (rsp_if.ready),
      .out_valid (rsp_if.valid),
      .data_out  (rsp_out),
      .can_load  (can_load)
   );

   // Response fields
   assign rsp_if.state_code      = rsp_out.state_code;
   assign rsp_if.busy_res        = rsp_out.busy_res;
   assign rsp_if.select_active   = rsp_out.select_active;
   assign rsp_if.start_accepted  = rsp_out.start_accepted;
   assign rsp_if.done_ack        = rsp_out.done_ack;
   assign rsp_if.request_command = rsp_out.request_command;
   assign rsp_if.request_read    = rsp_out.request_read;
   assign rsp_if.motion_status   = rsp_out.motion_status;
   assign rsp_if.delta_x         = rsp_out.delta_x;
   assign rsp_if.delta_y         = rsp_out.delta_y;
   assign rsp_if.surface_quality = rsp_out.surface_quality;

   // Assertions
   a_select_tracks_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (rsp_if.select_active == rsp_if.busy_res))
      else $error("chip select disagrees with busy");

   a_accept_enters_cmd: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.start_accepted) |->
         (rsp_if.request_command && rsp_if.state_code == PH_CMD))
      else $error("accepted start did not enter command phase");

   a_single_launch: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> !(rsp_if.request_command && rsp_if.request_read))
      else $error("command and read requested together");

   a_ack_to_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.done_ack) |-> (rsp_if.state_code == PH_IDLE))
      else $error("acknowledge did not return to idle");

   a_held_on_stall: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && !req_if.ready) |-> (rsp_if.valid && !rsp_if.ready))
      else $error("request stalled without a blocked response");

endmodule

`default_nettype wire
